// ===== design/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
package spr_pkg;

    localparam int BYTE_W      = 8;
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int WIN_DEPTH   = PATTERN_MAX - 1;
    localparam int SLOT_COUNT  = PATTERN_MAX;
    localparam int RUN_DEPTH   = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPLACE_BYTES  = 2'd2,
        CFG_REPLACE_LENGTH = 2'd3
    } t_cfg_idx;

endpackage

// ===== design/spr_in_if.sv =====
// Input channel: one text byte per transfer with a final-byte flag.
interface spr_in_if;
    logic             valid;
    logic             ready;
    spr_pkg::t_byte   text_byte;
    logic             text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// ===== design/spr_out_if.sv =====
// Output channel: one rewritten byte per transfer with run and text end flags.
interface spr_out_if;
    logic             valid;
    logic             ready;
    spr_pkg::t_byte   out_byte;
    logic             byte_valid;
    logic             run_last;
    logic             text_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output text_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input text_end, output ready);
endinterface

// ===== design/spr_win_cell.sv =====
// Window cell: holds one pending byte and compares its slot with a pattern byte.
module spr_win_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  spr_pkg::t_byte i_load_byte,
    input  spr_pkg::t_byte i_new_byte,
    input  logic           i_take_new,
    input  spr_pkg::t_byte i_pat_byte,
    output spr_pkg::t_byte o_slot,
    output logic           o_match
);

    spr_pkg::t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_load_byte;
        end
    end

    // the slot right after the last held byte sees the incoming byte
    assign o_slot  = i_take_new ? i_new_byte : r_byte;
    assign o_match = (o_slot == i_pat_byte);

endmodule

// ===== design/spr_run_cell.sv =====
// Run cell: holds one queued result byte and advances toward the output head.
module spr_run_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  spr_pkg::t_byte i_load_byte,
    input  logic           i_shift,
    input  spr_pkg::t_byte i_next_byte,
    output spr_pkg::t_byte o_byte
);

    spr_pkg::t_byte r_byte;
    spr_pkg::t_byte n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_load) begin
            n_byte = i_load_byte;
        end else if (i_shift) begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== design/stream_pattern_replace_unit.sv =====
// Stream find-and-replace: top level with window cells, run queue and output register.
// The first result of a byte passes through the run queue cells and the output register
// before it reaches the output port. Throughput: one input byte per cycle while each byte
// yields at most one result and the output does not stall; a byte yielding more than one
// result (up to 8) holds input ready low while the run queue drains.
// Reset (synchronous, active low) empties window, run queue and output register and
// restores pattern 0 of length 1 and an empty replacement.
module stream_pattern_replace_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    spr_in_if.sink                             i_text,
    spr_out_if.source                          o_text
);

    localparam int SLOT_W = $clog2(spr_pkg::SLOT_COUNT);
    localparam int WCNT_W = $clog2(spr_pkg::WIN_DEPTH + 1);

    // configuration
    logic [spr_pkg::CFG_DATA_W-1:0] r_pat;
    spr_pkg::t_len                  r_plen;
    logic [spr_pkg::CFG_DATA_W-1:0] r_repl;
    spr_pkg::t_len                  r_rlen;

    // window and run queue control
    logic [WCNT_W-1:0]              r_win_cnt;
    logic [WCNT_W-1:0]              n_win_cnt;
    spr_pkg::t_len                  r_run_cnt;
    spr_pkg::t_len                  n_run_cnt;
    logic                           r_run_end;
    logic                           r_run_bare;

    // output register
    logic                           r_out_vld;
    spr_pkg::t_byte                 r_out_byte;
    logic                           r_out_bv;
    logic                           r_out_rl;
    logic                           r_out_te;

    spr_pkg::t_byte                 slot      [spr_pkg::SLOT_COUNT];
    logic [spr_pkg::SLOT_COUNT-1:0] slot_eq;
    spr_pkg::t_byte                 win_load  [spr_pkg::WIN_DEPTH];
    spr_pkg::t_byte                 run_load  [spr_pkg::RUN_DEPTH];
    spr_pkg::t_byte                 run_byte  [spr_pkg::RUN_DEPTH];

    spr_pkg::t_len                  n_cur;
    spr_pkg::t_len                  plen_eff;
    spr_pkg::t_len                  rlen_eff;
    spr_pkg::t_len                  emit_cnt;
    logic                           match;
    logic                           replace;
    logic                           bare;
    logic                           in_xfer;
    logic                           out_free;
    logic                           move;

    assign out_free     = !r_out_vld || o_text.ready;
    assign move         = (r_run_cnt != '0) && out_free;
    assign i_text.ready = (r_run_cnt == '0) || ((r_run_cnt == 4'd1) && out_free);
    assign in_xfer      = i_text.valid && i_text.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= 4'd1;
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (spr_pkg::t_cfg_idx'(i_cfg_idx))
                spr_pkg::CFG_PATTERN_BYTES:  r_pat  <= i_cfg_data;
                spr_pkg::CFG_PATTERN_LENGTH: r_plen <= i_cfg_data[spr_pkg::LEN_W-1:0];
                spr_pkg::CFG_REPLACE_BYTES:  r_repl <= i_cfg_data;
                spr_pkg::CFG_REPLACE_LENGTH: r_rlen <= i_cfg_data[spr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // window cells
    for (genvar gi = 0; gi < spr_pkg::WIN_DEPTH; gi++) begin : g_win
        spr_win_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (in_xfer),
            .i_load_byte (win_load[gi]),
            .i_new_byte  (i_text.text_byte),
            .i_take_new  (r_win_cnt == WCNT_W'(gi)),
            .i_pat_byte  (r_pat[gi*spr_pkg::BYTE_W +: spr_pkg::BYTE_W]),
            .o_slot      (slot[gi]),
            .o_match     (slot_eq[gi])
        );
    end

    // the top slot only ever holds the incoming byte
    assign slot[spr_pkg::SLOT_COUNT-1]    = i_text.text_byte;
    assign slot_eq[spr_pkg::SLOT_COUNT-1] = (i_text.text_byte ==
        r_pat[(spr_pkg::SLOT_COUNT-1)*spr_pkg::BYTE_W +: spr_pkg::BYTE_W]);

    // step decision
    always_comb begin
        n_cur    = spr_pkg::LEN_W'(r_win_cnt) + 4'd1;
        plen_eff = r_plen;
        if (r_plen == '0) begin
            plen_eff = 4'd1;
        end else if (r_plen > spr_pkg::LEN_W'(spr_pkg::PATTERN_MAX)) begin
            plen_eff = spr_pkg::LEN_W'(spr_pkg::PATTERN_MAX);
        end
        rlen_eff = r_rlen;
        if (r_rlen > spr_pkg::LEN_W'(spr_pkg::REPLACE_MAX)) begin
            rlen_eff = spr_pkg::LEN_W'(spr_pkg::REPLACE_MAX);
        end

        match = 1'b1;
        for (int i = 0; i < spr_pkg::SLOT_COUNT; i++) begin
            if ((spr_pkg::LEN_W'(i) < plen_eff) && !slot_eq[i]) begin
                match = 1'b0;
            end
        end

        replace = (n_cur == plen_eff) && match;
        if (replace) begin
            emit_cnt = rlen_eff;
        end else if (i_text.text_last) begin
            emit_cnt = n_cur;
        end else if (n_cur > plen_eff) begin
            // pattern shortened: emit the oldest bytes until plen-1 remain
            emit_cnt = n_cur - plen_eff + 4'd1;
        end else if (n_cur == plen_eff) begin
            emit_cnt = 4'd1;
        end else begin
            emit_cnt = '0;
        end
        bare = i_text.text_last && (emit_cnt == '0);

        n_win_cnt = replace ? '0 : WCNT_W'(n_cur - emit_cnt);
    end

    // window reload: slots shifted down by the number of bytes emitted
    always_comb begin
        logic [spr_pkg::LEN_W-1:0] idx;
        for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
            idx = spr_pkg::LEN_W'(i) + emit_cnt;
            win_load[i] = idx[spr_pkg::LEN_W-1] ? '0 : slot[idx[SLOT_W-1:0]];
        end
    end

    always_comb begin
        for (int j = 0; j < spr_pkg::RUN_DEPTH; j++) begin
            run_load[j] = replace ? r_repl[j*spr_pkg::BYTE_W +: spr_pkg::BYTE_W] : slot[j];
        end
    end

    // run queue cells, head at index zero
    for (genvar gj = 0; gj < spr_pkg::RUN_DEPTH; gj++) begin : g_run
        spr_run_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (in_xfer),
            .i_load_byte (run_load[gj]),
            .i_shift     (move),
            .i_next_byte ((gj == spr_pkg::RUN_DEPTH - 1) ? '0 : run_byte[(gj + 1) % spr_pkg::RUN_DEPTH]),
            .o_byte      (run_byte[gj])
        );
    end

    always_comb begin
        n_run_cnt = r_run_cnt;
        if (in_xfer) begin
            n_run_cnt = bare ? 4'd1 : emit_cnt;
        end else if (move) begin
            n_run_cnt = r_run_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cnt  <= '0;
            r_run_cnt  <= '0;
            r_run_end  <= 1'b0;
            r_run_bare <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_run_cnt <= n_run_cnt;
            if (in_xfer) begin
                r_win_cnt  <= n_win_cnt;
                r_run_end  <= i_text.text_last;
                r_run_bare <= bare;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_text.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // hold the output payload until its transfer
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte <= r_run_bare ? '0 : run_byte[0];
            r_out_bv   <= !r_run_bare;
            r_out_rl   <= (r_run_cnt == 4'd1);
            r_out_te   <= (r_run_cnt == 4'd1) && r_run_end;
        end
    end

    assign o_text.valid      = r_out_vld;
    assign o_text.out_byte   = r_out_byte;
    assign o_text.byte_valid = r_out_bv;
    assign o_text.run_last   = r_out_rl;
    assign o_text.text_end   = r_out_te;

endmodule

// ===== design/spr_checker.sv =====
// Port-level checks for the stream pattern replace block, bound to the top level.
module spr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input spr_pkg::t_byte i_out_byte,
    input logic           i_byte_valid,
    input logic           i_run_last,
    input logic           i_text_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_byte_valid) && $stable(i_run_last) && $stable(i_text_end))
        else $error("output changed while stalled");

    // a bare end marker closes both the run and the text and carries a zero byte
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_run_last && i_text_end && (i_out_byte == '0))
        else $error("malformed end marker");

    // the end of the text is always the end of a run
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_text_end |-> i_run_last)
        else $error("text end without run end");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind stream_pattern_replace_unit spr_checker u_spr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_text.valid),
    .i_out_ready  (o_text.ready),
    .i_out_byte   (o_text.out_byte),
    .i_byte_valid (o_text.byte_valid),
    .i_run_last   (o_text.run_last),
    .i_text_end   (o_text.text_end)
);
